>>> rtl/ucf_pkg.sv
package ucf_pkg;

    localparam int FIELD_W = 11;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam int          ADDR_W         = 3;
    localparam logic [2:0]  ADDR_NODE_COUNT = 3'd0;
    localparam logic [10:0] NODE_COUNT_RST = 11'd1024;

    typedef struct packed {
        logic               rejected;
        logic               found;
        logic [FIELD_W-1:0] cycle_length;
        logic [FIELD_W-1:0] cycle_node;
    } ucf_result_t;

endpackage

>>> rtl/ucf_result_reg.sv
module ucf_result_reg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  ucf_pkg::ucf_result_t                res_in,
    output logic                                free,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_rejected,
    output logic                                m_found,
    output logic [ucf_pkg::FIELD_W-1:0]         m_cycle_length,
    output logic [ucf_pkg::FIELD_W-1:0]         m_cycle_node
);

    logic                 valid_reg;
    ucf_pkg::ucf_result_t res_reg;

    // Slot is free when empty or when its beat leaves this cycle.
    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_valid        = valid_reg;
    assign m_rejected     = res_reg.rejected;
    assign m_found        = res_reg.found;
    assign m_cycle_length = res_reg.cycle_length;
    assign m_cycle_node   = res_reg.cycle_node;

endmodule

>>> rtl/undirected_cycle_finder.sv
// Channel   | Handshake           | Payload
// s_ (in)   | s_valid / s_ready   | s_mode, s_first_node, s_second_node, s_position
// m_ (out)  | m_valid / m_ready   | m_rejected, m_found, m_cycle_length, m_cycle_node
// cfg (APB) | psel/penable/pready | paddr, pwrite, pwdata, prdata (node_count at 0x0)
//
// Flow: one item at a time. An edge load is set by the read-modify-write of the tail
//   and link memories, once for each of its two halves.
// A search first clears the visited memory, then visits each root, walks half edges,
//   pops nodes and stores the cycle entries that it finds.
// Reset: synchronous, active low; afterwards a pass clears the list heads, tails
//   and visited marks while s_ready stays low.
// Stalls: a finished beat waits in the output register; the next item is taken
//   meanwhile and holds in its last state only if its own result finds the slot full.
module undirected_cycle_finder #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic [ucf_pkg::FIELD_W-1:0]   s_first_node,
    input  logic [ucf_pkg::FIELD_W-1:0]   s_second_node,
    input  logic [ucf_pkg::FIELD_W-1:0]   s_position,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_rejected,
    output logic                          m_found,
    output logic [ucf_pkg::FIELD_W-1:0]   m_cycle_length,
    output logic [ucf_pkg::FIELD_W-1:0]   m_cycle_node,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ucf_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int HALF  = 2 * MAX_EDGES;
    localparam int NW    = $clog2(MAX_NODES + 1);  // node value, node memory index
    localparam int SPW   = $clog2(MAX_NODES + 2);  // stack depth, root counter
    localparam int CW    = $clog2(MAX_NODES + 2);  // cycle store index
    localparam int LENW  = $clog2(MAX_NODES + 3);  // cycle length
    localparam int LW    = $clog2(HALF + 1);       // link value, half edge count
    localparam int EIW   = $clog2(HALF);           // half edge memory index
    localparam int SKW   = NW + LW;                // stack entry {node, link}
    localparam int FW    = ucf_pkg::FIELD_W;

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE, ST_LD_RD, ST_LD_WA, ST_LD_WB, ST_RD_WAIT,
        ST_ROOT, ST_ROOT_CHK, ST_STEP, ST_EDGE_WAIT, ST_VIS_WAIT,
        ST_POP_WAIT, ST_PAR_WAIT, ST_CYC, ST_CYC_WAIT, ST_CYC_U, ST_DONE
    } state_t;

    // ---------------- memories ----------------
    logic [LW-1:0]  head_mem [MAX_NODES+1];
    logic [LW-1:0]  tail_mem [MAX_NODES+1];
    logic           vis_mem  [MAX_NODES+1];
    logic [NW-1:0]  par_mem  [MAX_NODES+1];
    logic [SKW-1:0] stk_mem  [MAX_NODES+1];
    logic [NW-1:0]  tgt_mem  [HALF];
    logic [LW-1:0]  nxt_mem  [HALF];
    logic [NW-1:0]  cyc_mem  [MAX_NODES+2];

    logic           head_we, tail_we, vis_we, par_we, stk_we, tgt_we, nxt_we, cyc_we;
    logic [NW-1:0]  head_wa, tail_wa, vis_wa, par_wa, stk_wa;
    logic [NW-1:0]  head_ra, tail_ra, vis_ra, par_ra, stk_ra;
    logic [EIW-1:0] tgt_wa, nxt_wa, edge_ra;
    logic [CW-1:0]  cyc_wa, cyc_ra;
    logic [LW-1:0]  head_wd, tail_wd, nxt_wd;
    logic           vis_wd;
    logic [NW-1:0]  par_wd, tgt_wd, cyc_wd;
    logic [SKW-1:0] stk_wd;
    logic [LW-1:0]  head_rd, tail_rd, nxt_rd;
    logic           vis_rd;
    logic [NW-1:0]  par_rd, tgt_rd, cyc_rd;
    logic [SKW-1:0] stk_rd;

    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        head_rd <= head_mem[head_ra];
    end
    always_ff @(posedge aclk) begin
        if (tail_we) tail_mem[tail_wa] <= tail_wd;
        tail_rd <= tail_mem[tail_ra];
    end
    always_ff @(posedge aclk) begin
        if (vis_we) vis_mem[vis_wa] <= vis_wd;
        vis_rd <= vis_mem[vis_ra];
    end
    always_ff @(posedge aclk) begin
        if (par_we) par_mem[par_wa] <= par_wd;
        par_rd <= par_mem[par_ra];
    end
    always_ff @(posedge aclk) begin
        if (stk_we) stk_mem[stk_wa] <= stk_wd;
        stk_rd <= stk_mem[stk_ra];
    end
    always_ff @(posedge aclk) begin
        if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
        tgt_rd <= tgt_mem[edge_ra];
    end
    always_ff @(posedge aclk) begin
        if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
        nxt_rd <= nxt_mem[edge_ra];
    end
    always_ff @(posedge aclk) begin
        if (cyc_we) cyc_mem[cyc_wa] <= cyc_wd;
        cyc_rd <= cyc_mem[cyc_ra];
    end

    // ---------------- control registers ----------------
    state_t          state_reg;
    logic            clr_all_reg;
    logic [NW-1:0]   clr_idx_reg;
    logic [10:0]     node_count_reg;
    logic [LW-1:0]   hcount_reg;
    logic [LENW-1:0] stored_len_reg;
    logic [NW-1:0]   x_reg, y_reg;
    logic            half_reg;
    logic [LW-1:0]   t_reg;
    logic [SPW-1:0]  root_reg, sp_reg;
    logic [NW-1:0]   u_reg, pu_reg, v_reg, w_reg, cu_reg;
    logic [LW-1:0]   e_reg;
    logic [LENW-1:0] len_reg;
    logic            rej_reg;
    logic [NW-1:0]   node_reg;

    logic [31:0] eff_nodes;
    logic        ld_reject, rd_ok, res_free, res_load, edge_end, cyc_go;
    ucf_pkg::ucf_result_t res;

    assign eff_nodes = (32'(node_count_reg) > 32'(MAX_NODES)) ? 32'(MAX_NODES)
                                                                : 32'(node_count_reg);
    assign ld_reject = (s_first_node == '0) || (s_second_node == '0) ||
                       (32'(s_first_node) > eff_nodes) || (32'(s_second_node) > eff_nodes) ||
                       (32'(hcount_reg) + 32'd2 > 32'(HALF));
    assign rd_ok     = (32'(s_position) < 32'(stored_len_reg)) &&
                       (32'(s_position) < 32'(MAX_NODES + 2));
    assign edge_end  = (e_reg == '0) || (32'(e_reg) > 32'(HALF));
    assign cyc_go    = (w_reg != v_reg) && (w_reg != '0) &&
                       (32'(w_reg) <= 32'(MAX_NODES)) && (32'(len_reg) < 32'(MAX_NODES));

    assign s_ready  = (state_reg == ST_IDLE);
    assign res_load = (state_reg == ST_DONE) && res_free;

    assign res.rejected     = rej_reg;
    assign res.found        = (stored_len_reg != '0);
    assign res.cycle_length = FW'(stored_len_reg);
    assign res.cycle_node   = FW'(node_reg);

    // ---------------- memory port steering ----------------
    always_comb begin
        head_we = 1'b0; tail_we = 1'b0; vis_we = 1'b0; par_we = 1'b0;
        stk_we  = 1'b0; tgt_we  = 1'b0; nxt_we = 1'b0; cyc_we = 1'b0;
        head_wa = '0; tail_wa = '0; vis_wa = '0; par_wa = '0; stk_wa = '0;
        tgt_wa  = '0; nxt_wa  = '0; cyc_wa = '0;
        head_wd = '0; tail_wd = '0; nxt_wd = '0; vis_wd = 1'b0;
        par_wd  = '0; tgt_wd  = '0; cyc_wd = '0; stk_wd = '0;
        head_ra = '0; tail_ra = '0; vis_ra = '0; par_ra = '0; stk_ra = '0;
        edge_ra = '0; cyc_ra  = CW'(s_position);
        case (state_reg)
            ST_CLR: begin
                vis_we  = 1'b1;
                vis_wa  = clr_idx_reg;
                head_we = clr_all_reg;
                head_wa = clr_idx_reg;
                tail_we = clr_all_reg;
                tail_wa = clr_idx_reg;
            end
            ST_LD_RD: begin
                tail_ra = x_reg;
            end
            ST_LD_WA: begin
                tgt_we  = 1'b1;
                tgt_wa  = EIW'(hcount_reg);
                tgt_wd  = y_reg;
                nxt_we  = 1'b1;
                nxt_wa  = EIW'(hcount_reg);
                tail_we = 1'b1;
                tail_wa = x_reg;
                tail_wd = hcount_reg + LW'(1);
                head_we = (tail_rd == '0);
                head_wa = x_reg;
                head_wd = hcount_reg + LW'(1);
            end
            ST_LD_WB: begin
                nxt_we = (t_reg != '0);
                nxt_wa = EIW'(t_reg - LW'(1));
                nxt_wd = hcount_reg + LW'(1);
            end
            ST_ROOT: begin
                head_ra = NW'(root_reg);
                vis_ra  = NW'(root_reg);
            end
            ST_ROOT_CHK: begin
                vis_we = !vis_rd;
                vis_wa = NW'(root_reg);
                vis_wd = 1'b1;
                par_we = !vis_rd;
                par_wa = NW'(root_reg);
            end
            ST_STEP: begin
                edge_ra = EIW'(e_reg - LW'(1));
                stk_ra  = NW'(sp_reg - SPW'(2));
            end
            ST_POP_WAIT: begin
                par_ra = stk_rd[SKW-1:LW];
            end
            ST_EDGE_WAIT: begin
                vis_ra  = tgt_rd;
                par_ra  = tgt_rd;
                head_ra = tgt_rd;
            end
            ST_VIS_WAIT: begin
                if (!vis_rd && (32'(sp_reg) <= 32'(MAX_NODES))) begin
                    vis_we = 1'b1;
                    vis_wa = v_reg;
                    vis_wd = 1'b1;
                    par_we = 1'b1;
                    par_wa = v_reg;
                    par_wd = u_reg;
                    stk_we = 1'b1;
                    stk_wa = NW'(sp_reg - SPW'(1));
                    stk_wd = {u_reg, e_reg};
                end
            end
            ST_CYC: begin
                cyc_we = 1'b1;
                cyc_wa = CW'(len_reg);
                cyc_wd = cyc_go ? w_reg : v_reg;
                par_ra = w_reg;
            end
            ST_CYC_U: begin
                cyc_we = 1'b1;
                cyc_wa = CW'(len_reg);
                cyc_wd = cu_reg;
            end
            default: begin
            end
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLR;
            clr_all_reg    <= 1'b1;
            clr_idx_reg    <= '0;
            node_count_reg <= ucf_pkg::NODE_COUNT_RST;
            hcount_reg     <= '0;
            stored_len_reg <= '0;
            rej_reg        <= 1'b0;
            node_reg       <= '0;
        end else begin
            if (psel && penable && pwrite && (paddr == ucf_pkg::ADDR_NODE_COUNT)) begin
                node_count_reg <= pwdata[10:0];
            end
            case (state_reg)
                ST_CLR: begin
                    clr_idx_reg <= clr_idx_reg + NW'(1);
                    if (clr_idx_reg == NW'(MAX_NODES)) begin
                        clr_idx_reg <= '0;
                        clr_all_reg <= 1'b0;
                        root_reg    <= SPW'(1);
                        state_reg   <= clr_all_reg ? ST_IDLE : ST_ROOT;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        rej_reg  <= 1'b0;
                        node_reg <= '0;
                        x_reg    <= NW'(s_first_node);
                        y_reg    <= NW'(s_second_node);
                        half_reg <= 1'b0;
                        if (s_mode == ucf_pkg::MODE_LOAD) begin
                            rej_reg   <= ld_reject;
                            state_reg <= ld_reject ? ST_DONE : ST_LD_RD;
                        end else if (s_mode == ucf_pkg::MODE_SEARCH) begin
                            stored_len_reg <= '0;
                            state_reg      <= ST_CLR;
                        end else if (s_mode == ucf_pkg::MODE_READ) begin
                            rej_reg   <= !rd_ok;
                            state_reg <= rd_ok ? ST_RD_WAIT : ST_DONE;
                        end else begin
                            rej_reg   <= 1'b1;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_RD_WAIT: begin
                    node_reg  <= cyc_rd;
                    state_reg <= ST_DONE;
                end
                ST_LD_RD: begin
                    state_reg <= ST_LD_WA;
                end
                ST_LD_WA: begin
                    t_reg     <= tail_rd;
                    state_reg <= ST_LD_WB;
                end
                ST_LD_WB: begin
                    // advance the count, then append the reverse half
                    hcount_reg <= hcount_reg + LW'(1);
                    if (!half_reg) begin
                        half_reg  <= 1'b1;
                        x_reg     <= y_reg;
                        y_reg     <= x_reg;
                        state_reg <= ST_LD_RD;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_ROOT: begin
                    state_reg <= (32'(root_reg) > eff_nodes) ? ST_DONE : ST_ROOT_CHK;
                end
                ST_ROOT_CHK: begin
                    if (vis_rd) begin
                        root_reg  <= root_reg + SPW'(1);
                        state_reg <= ST_ROOT;
                    end else begin
                        u_reg     <= NW'(root_reg);
                        e_reg     <= head_rd;
                        pu_reg    <= '0;
                        sp_reg    <= SPW'(1);
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    if (edge_end) begin
                        if (sp_reg == SPW'(1)) begin
                            root_reg  <= root_reg + SPW'(1);
                            state_reg <= ST_ROOT;
                        end else begin
                            sp_reg    <= sp_reg - SPW'(1);
                            state_reg <= ST_POP_WAIT;
                        end
                    end else begin
                        state_reg <= ST_EDGE_WAIT;
                    end
                end
                ST_POP_WAIT: begin
                    u_reg     <= stk_rd[SKW-1:LW];
                    e_reg     <= stk_rd[LW-1:0];
                    state_reg <= ST_PAR_WAIT;
                end
                ST_PAR_WAIT: begin
                    pu_reg    <= par_rd;
                    state_reg <= ST_STEP;
                end
                ST_EDGE_WAIT: begin
                    e_reg <= nxt_rd;
                    v_reg <= tgt_rd;
                    if ((tgt_rd == '0) || (32'(tgt_rd) > 32'(MAX_NODES)) ||
                        (tgt_rd == pu_reg)) begin
                        state_reg <= ST_STEP;
                    end else begin
                        state_reg <= ST_VIS_WAIT;
                    end
                end
                ST_VIS_WAIT: begin
                    if (vis_rd) begin
                        if ((v_reg != u_reg) && (par_rd == u_reg)) begin
                            state_reg <= ST_STEP;
                        end else begin
                            cu_reg    <= u_reg;
                            w_reg     <= u_reg;
                            len_reg   <= '0;
                            state_reg <= ST_CYC;
                        end
                    end else if (32'(sp_reg) > 32'(MAX_NODES)) begin
                        state_reg <= ST_STEP;
                    end else begin
                        // push the current node, descend into v
                        u_reg     <= v_reg;
                        pu_reg    <= u_reg;
                        e_reg     <= head_rd;
                        sp_reg    <= sp_reg + SPW'(1);
                        state_reg <= ST_STEP;
                    end
                end
                ST_CYC: begin
                    len_reg   <= len_reg + LENW'(1);
                    state_reg <= cyc_go ? ST_CYC_WAIT : ST_CYC_U;
                end
                ST_CYC_WAIT: begin
                    w_reg     <= par_rd;
                    state_reg <= ST_CYC;
                end
                ST_CYC_U: begin
                    stored_len_reg <= len_reg + LENW'(1);
                    state_reg      <= ST_DONE;
                end
                ST_DONE: begin
                    if (res_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ucf_pkg::ADDR_NODE_COUNT) ? {21'd0, node_count_reg} : 32'd0;

    ucf_result_reg u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (res_load),
        .res_in         (res),
        .free           (res_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rejected     (m_rejected),
        .m_found        (m_found),
        .m_cycle_length (m_cycle_length),
        .m_cycle_node   (m_cycle_node)
    );

    // ---------------- checks ----------------
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while one is in flight");
    a_hcount: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(hcount_reg) <= 32'(HALF))
        else $error("half edge count beyond store");
    a_stack: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |-> (sp_reg != '0) && (32'(sp_reg) <= 32'(MAX_NODES) + 1))
        else $error("walk stack depth out of range");
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(stored_len_reg) <= 32'(MAX_NODES) + 2)
        else $error("stored cycle length out of range");
    a_push: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> m_valid)
        else $error("result lost at output register");

endmodule
